FILE: rtl/risc_subset_decode_execute_top_defines.svh
// Assertion helpers for the decode/execute block
`ifndef RISC_SUBSET_DECODE_EXECUTE_TOP_DEFINES_SVH
`define RISC_SUBSET_DECODE_EXECUTE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RSDE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rsde check failed");

// Next-cycle implication, checked outside reset
`define RSDE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rsde check failed");

`endif

FILE: rtl/rsde_pkg.sv
package rsde_pkg;

   localparam int DATA_WORDS = 256;
   localparam int DS_AW      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
   localparam int PC_W       = 26;
   localparam int RF_AW      = 5;
   localparam int CSR_AW     = 3;

   localparam logic [31:0]     BASE_RESET = 32'h0000_0080;
   localparam logic [PC_W-1:0] CODE_BASE  = 26'd32;

   // Command codes
   localparam logic CMD_EXECUTE = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   // Categories (bits 31..29)
   localparam logic [2:0] CAT_CTRL = 3'b000;
   localparam logic [2:0] CAT_REG  = 3'b110;
   localparam logic [2:0] CAT_IMM  = 3'b111;

   // Control opcodes (bits 28..26)
   localparam logic [2:0] OP_J     = 3'd0;
   localparam logic [2:0] OP_BEQ   = 3'd2;
   localparam logic [2:0] OP_BGTZ  = 3'd4;
   localparam logic [2:0] OP_BREAK = 3'd5;
   localparam logic [2:0] OP_SW    = 3'd6;
   localparam logic [2:0] OP_LW    = 3'd7;

   // Register and immediate opcodes (bits 18..16)
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_AND = 3'd3;
   localparam logic [2:0] OP_OR  = 3'd4;
   localparam logic [2:0] OP_XOR = 3'd5;
   localparam logic [2:0] OP_NOR = 3'd6;
   localparam logic [2:0] OP_ADDI = 3'd0;
   localparam logic [2:0] OP_ANDI = 3'd1;
   localparam logic [2:0] OP_ORI  = 3'd2;
   localparam logic [2:0] OP_XORI = 3'd3;

   // Register indexes of the CSR port
   localparam logic [CSR_AW-1:0] CSR_DATA_BASE = 3'd0;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   // Outcome of the execute stage
   typedef struct packed {
      logic [PC_W-1:0]  next_pc;
      logic             halt;
      logic             upd_pc;
      logic             wrote;
      logic [RF_AW-1:0] widx;
      logic [31:0]      value;
      logic             is_load;
      status_type       status;
      logic             ds_we;
      logic             ds_re;
      logic [DS_AW-1:0] ds_idx;
      logic [31:0]      ds_wdata;
   } exec_res_type;

endpackage

FILE: rtl/rsde_if.sv
interface rsde_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic [31:0]        instruction_word;
   logic [7:0]         preload_index;
   logic signed [31:0] preload_value;

   modport source (output valid, command, instruction_word, preload_index, preload_value,
                   input ready);
   modport sink   (input valid, command, instruction_word, preload_index, preload_value,
                   output ready);
endinterface

interface rsde_rsp_if;
   logic               valid;
   logic               ready;
   logic [25:0]        next_pc;
   logic               halted;
   logic               wrote_register;
   logic [4:0]         written_index;
   logic signed [31:0] written_value;
   logic [1:0]         status;

   modport source (output valid, next_pc, halted, wrote_register, written_index,
                   written_value, status, input ready);
   modport sink   (input valid, next_pc, halted, wrote_register, written_index,
                   written_value, status, output ready);
endinterface

FILE: rtl/rsde_regfile.sv
module rsde_regfile
   import rsde_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [RF_AW-1:0] rd_addr0,
   input  logic [RF_AW-1:0] rd_addr1,
   output logic [31:0]      rd_data0,
   output logic [31:0]      rd_data1,
   input  logic             wr_en,
   input  logic [RF_AW-1:0] wr_addr,
   input  logic [31:0]      wr_data
);

   localparam int RF_DEPTH = 1 << RF_AW;

   logic [31:0]         mem [RF_DEPTH];
   logic [RF_DEPTH-1:0] valid_ff;
   logic [31:0]         rd0_ff;
   logic [31:0]         rd1_ff;

   // Track written entries; an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read with bypass of a write at the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr0) begin
            rd0_ff <= wr_data;
         end else begin
            rd0_ff <= valid_ff[rd_addr0] ? mem[rd_addr0] : 32'd0;
         end
         if (wr_en && wr_addr == rd_addr1) begin
            rd1_ff <= wr_data;
         end else begin
            rd1_ff <= valid_ff[rd_addr1] ? mem[rd_addr1] : 32'd0;
         end
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

FILE: rtl/rsde_dstore.sv
module rsde_dstore
   import rsde_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [DS_AW-1:0] addr,
   input  logic [31:0]      wr_data,
   output logic [31:0]      rd_data
);

   logic [31:0] mem [DATA_WORDS];
   logic [31:0] rd_ff;

   // Single port: one write or one read per item
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

FILE: rtl/rsde_exec.sv
module rsde_exec
   import rsde_pkg::*;
(
   input  logic            command,
   input  logic [31:0]     instr,
   input  logic [7:0]      preload_index,
   input  logic [31:0]     preload_value,
   input  logic [31:0]     opa,
   input  logic [31:0]     opb,
   input  logic [PC_W-1:0] pc,
   input  logic            halt,
   input  logic [31:0]     base,
   output exec_res_type    res
);

   logic [31:0]     addr;
   logic [PC_W-1:0] branch_pc;
   logic            in_range;
   logic            pre_in_range;

   assign addr         = opa + {16'd0, instr[15:0]} - base;
   assign branch_pc    = pc + 26'd1 + {{10{instr[15]}}, instr[15:0]};
   assign in_range     = ({2'b00, addr[31:2]} < 32'(DATA_WORDS));
   assign pre_in_range = ({24'd0, preload_index} < 32'(DATA_WORDS));

   // Decode and execute one item
   always_comb begin
      res         = '0;
      res.next_pc = pc;
      res.halt    = halt;
      res.status  = ST_OK;
      if (command == CMD_PRELOAD) begin
         if (pre_in_range) begin
            res.ds_we    = 1'b1;
            res.ds_idx   = DS_AW'(preload_index);
            res.ds_wdata = preload_value;
         end else begin
            res.status = ST_RANGE;
         end
      end else if (!halt) begin
         res.upd_pc  = 1'b1;
         res.next_pc = pc + 26'd1;
         case (instr[31:29])
            CAT_CTRL: begin
               case (instr[28:26])
                  OP_J: res.next_pc = instr[25:0] - CODE_BASE;
                  OP_BEQ: begin
                     if (opa == opb) res.next_pc = branch_pc;
                  end
                  OP_BGTZ: begin
                     if (!opa[31] && opa != 32'd0) res.next_pc = branch_pc;
                  end
                  OP_BREAK: res.halt = 1'b1;
                  OP_SW, OP_LW: begin
                     if (!in_range) begin
                        res.status = ST_RANGE;
                     end else if (instr[28:26] == OP_SW) begin
                        res.ds_we    = 1'b1;
                        res.ds_idx   = DS_AW'(addr[31:2]);
                        res.ds_wdata = opb;
                     end else begin
                        res.ds_re   = 1'b1;
                        res.ds_idx  = DS_AW'(addr[31:2]);
                        res.is_load = 1'b1;
                        res.wrote   = 1'b1;
                        res.widx    = instr[20:16];
                     end
                  end
                  default: res.status = ST_UNKNOWN;
               endcase
            end
            CAT_REG: begin
               res.wrote = 1'b1;
               res.widx  = instr[15:11];
               case (instr[18:16])
                  OP_ADD: res.value = opa + opb;
                  OP_SUB: res.value = opa - opb;
                  OP_MUL: res.value = opa * opb;
                  OP_AND: res.value = opa & opb;
                  OP_OR:  res.value = opa | opb;
                  OP_XOR: res.value = opa ^ opb;
                  OP_NOR: res.value = ~(opa | opb);
                  default: begin
                     res.wrote  = 1'b0;
                     res.widx   = '0;
                     res.status = ST_UNKNOWN;
                  end
               endcase
            end
            CAT_IMM: begin
               res.wrote = 1'b1;
               res.widx  = instr[28:24];
               case (instr[18:16])
                  OP_ADDI: res.value = opb + {24'd0, instr[7:0]};
                  OP_ANDI: res.value = opb & {24'd0, instr[7:0]};
                  OP_ORI:  res.value = opb | {24'd0, instr[7:0]};
                  OP_XORI: res.value = opb ^ {24'd0, instr[7:0]};
                  default: begin
                     res.wrote  = 1'b0;
                     res.widx   = '0;
                     res.status = ST_UNKNOWN;
                  end
               endcase
            end
            default: res.status = ST_UNKNOWN;
         endcase
      end
   end

endmodule

FILE: rtl/risc_subset_decode_execute_top.sv
// Decode/execute core for a small MIPS-like instruction set.
// Input channel req_ch carries one item per command: execute the word at the
// current PC, or preload one data store word. Output channel rsp_ch returns
// exactly one result item per input item, in order: next PC, halt bit,
// register write and status. Both channels use valid/ready.
// APB register: data base address, read at address 0, written when paddr[2] is 0.
// An accepted item is registered in the execute stage, then in the output stage
// that offers its result. One item is accepted every cycle unless rsp_ch stalls:
// register file operands are read as the item enters, the execute stage forwards
// the result still in the output register, and a load reads the single-port data
// store as it leaves execute. The register file is written as the result leaves.
// Reset clears the PC, halt bit, pipeline valids and the register file
// valid bits (all registers read as zero); the data store is not cleared.
// When rsp_ch stalls, the whole pipeline holds and req_ch.ready drops.
`include "risc_subset_decode_execute_top_defines.svh"

module risc_subset_decode_execute_top
   import rsde_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   rsde_req_if.sink          req_ch,
   rsde_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic             adv;
   logic [31:0]      base_ff;
   logic [PC_W-1:0]  pc_ff;
   logic             halt_ff;

   // Execute stage registers
   logic             s1_v_ff;
   logic             s1_cmd_ff;
   logic [31:0]      s1_instr_ff;
   logic [7:0]       s1_pidx_ff;
   logic [31:0]      s1_pval_ff;
   logic [RF_AW-1:0] s1_ra0_ff;
   logic [RF_AW-1:0] s1_ra1_ff;

   // Output stage registers
   logic             s2_v_ff;
   logic [PC_W-1:0]  s2_pc_ff;
   logic             s2_halt_ff;
   logic             s2_wrote_ff;
   logic [RF_AW-1:0] s2_widx_ff;
   logic [31:0]      s2_value_ff;
   logic             s2_load_ff;
   status_type       s2_status_ff;

   logic [RF_AW-1:0] ra0;
   logic [RF_AW-1:0] ra1;
   logic [31:0]      rf_rd0;
   logic [31:0]      rf_rd1;
   logic [31:0]      ds_rdata;
   logic [31:0]      wb_value;
   logic             rf_we;
   logic [31:0]      opa;
   logic [31:0]      opb;
   logic             s1_fire;
   exec_res_type     res;

   assign adv          = !s2_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign s1_fire      = adv && s1_v_ff;

   // Register config access
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_DATA_BASE) ? base_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         base_ff <= pwdata;
      end
   end

   // Pick operand fields by category
   assign ra0 = (req_ch.instruction_word[31:29] == CAT_CTRL) ?
                req_ch.instruction_word[25:21] : req_ch.instruction_word[28:24];
   assign ra1 = (req_ch.instruction_word[31:29] == CAT_CTRL) ?
                req_ch.instruction_word[20:16] : req_ch.instruction_word[23:19];

   assign wb_value = s2_load_ff ? ds_rdata : s2_value_ff;
   assign rf_we    = s2_v_ff && rsp_ch.ready && s2_wrote_ff;

   rsde_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (adv),
      .rd_addr0 (ra0),
      .rd_addr1 (ra1),
      .rd_data0 (rf_rd0),
      .rd_data1 (rf_rd1),
      .wr_en    (rf_we),
      .wr_addr  (s2_widx_ff),
      .wr_data  (wb_value)
   );

   // Forward the result waiting in the output stage
   assign opa = (s2_v_ff && s2_wrote_ff && s2_widx_ff == s1_ra0_ff) ? wb_value : rf_rd0;
   assign opb = (s2_v_ff && s2_wrote_ff && s2_widx_ff == s1_ra1_ff) ? wb_value : rf_rd1;

   rsde_exec u_exec (
      .command       (s1_cmd_ff),
      .instr         (s1_instr_ff),
      .preload_index (s1_pidx_ff),
      .preload_value (s1_pval_ff),
      .opa           (opa),
      .opb           (opb),
      .pc            (pc_ff),
      .halt          (halt_ff),
      .base          (base_ff),
      .res           (res)
   );

   rsde_dstore u_dstore (
      .clock   (clock),
      .wr_en   (s1_fire && res.ds_we),
      .rd_en   (s1_fire && res.ds_re),
      .addr    (res.ds_idx),
      .wr_data (res.ds_wdata),
      .rd_data (ds_rdata)
   );

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         pc_ff   <= '0;
         halt_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_ch.valid;
         s2_v_ff <= s1_v_ff;
         if (s1_v_ff) begin
            halt_ff <= res.halt;
            if (res.upd_pc) pc_ff <= res.next_pc;
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff    <= req_ch.command;
         s1_instr_ff  <= req_ch.instruction_word;
         s1_pidx_ff   <= req_ch.preload_index;
         s1_pval_ff   <= req_ch.preload_value;
         s1_ra0_ff    <= ra0;
         s1_ra1_ff    <= ra1;
         s2_pc_ff     <= res.next_pc;
         s2_halt_ff   <= res.halt;
         s2_wrote_ff  <= res.wrote;
         s2_widx_ff   <= res.widx;
         s2_value_ff  <= res.value;
         s2_load_ff   <= res.is_load;
         s2_status_ff <= res.status;
      end
   end

   assign rsp_ch.valid          = s2_v_ff;
   assign rsp_ch.next_pc        = s2_pc_ff;
   assign rsp_ch.halted         = s2_halt_ff;
   assign rsp_ch.wrote_register = s2_wrote_ff;
   assign rsp_ch.written_index  = s2_widx_ff;
   assign rsp_ch.written_value  = wb_value;
   assign rsp_ch.status         = 2'(s2_status_ff);

   `RSDE_ASSERT_NEXT(a_halt_sticky, halt_ff, halt_ff)
   `RSDE_ASSERT_NEXT(a_pc_hold, !adv, $stable(pc_ff))
   `RSDE_ASSERT_SAME(a_write_ok, s2_v_ff && s2_wrote_ff, s2_status_ff == ST_OK)

endmodule

FILE: sim/risc_subset_decode_execute_top_tb.sv
`timescale 1ns / 100ps

module risc_subset_decode_execute_top_tb;
   import rsde_pkg::*;

   typedef struct packed {
      logic [PC_W-1:0] next_pc;
      logic            halted;
      logic            wrote;
      logic [4:0]      widx;
      logic [31:0]     wval;
      status_type      status;
   } core_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   rsde_req_if req_ch ();
   rsde_rsp_if rsp_ch ();

   risc_subset_decode_execute_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   // Shadow copy of the core state
   logic [31:0]     shadow_regs [32];
   logic [31:0]     shadow_mem  [DATA_WORDS];
   logic [PC_W-1:0] shadow_pc;
   logic            shadow_halt;
   logic [31:0]     shadow_base;

   core_result_type pending_results[$];
   int  errors = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  mem_hits = 0;
   int  branches_taken = 0;
   bit  idle_on = 1'b1;
   int  stall_requests = 0;
   int  stall_served = 0;
   int  hold_left = 0;
   int  rsp_gap = 0;

   always #4 clock = ~clock;

   // Work out the result of one item and advance the shadow state
   function automatic core_result_type core_predict(logic cmd, logic [31:0] w,
                                                    logic [7:0] pidx, logic [31:0] pval);
      core_result_type r;
      logic [2:0]  cat, op, rop;
      logic [4:0]  rs, rt, fa, fb, dst;
      logic [31:0] off16, sext, va, vb, addr, wordi, res;
      bit ok;
      r = '0;
      r.next_pc = shadow_pc;
      r.status = ST_OK;
      if (cmd == CMD_PRELOAD) begin
         if (pidx < DATA_WORDS) shadow_mem[pidx] = pval;
         else r.status = ST_RANGE;
      end else if (!shadow_halt) begin
         cat = w[31:29];
         r.next_pc = shadow_pc + 1'b1;
         if (cat == CAT_CTRL) begin
            op = w[28:26]; rs = w[25:21]; rt = w[20:16];
            off16 = {16'd0, w[15:0]};
            sext = {{16{w[15]}}, w[15:0]};
            va = shadow_regs[rs]; vb = shadow_regs[rt];
            case (op)
               OP_J: r.next_pc = w[25:0] - CODE_BASE;
               OP_BEQ: if (va == vb) begin
                  r.next_pc = PC_W'(shadow_pc + 1 + sext); branches_taken++;
               end
               OP_BGTZ: if ($signed(va) > 0) begin
                  r.next_pc = PC_W'(shadow_pc + 1 + sext); branches_taken++;
               end
               OP_BREAK: shadow_halt = 1'b1;
               OP_SW, OP_LW: begin
                  addr = va + off16 - shadow_base;
                  wordi = addr >> 2;
                  if (wordi >= DATA_WORDS) r.status = ST_RANGE;
                  else begin
                     mem_hits++;
                     if (op == OP_SW) shadow_mem[wordi] = vb;
                     else begin
                        shadow_regs[rt] = shadow_mem[wordi];
                        r.wrote = 1'b1; r.widx = rt; r.wval = shadow_mem[wordi];
                     end
                  end
               end
               default: r.status = ST_UNKNOWN;
            endcase
         end else if (cat == CAT_REG || cat == CAT_IMM) begin
            rop = w[18:16]; fa = w[28:24]; fb = w[23:19];
            vb = shadow_regs[fb];
            ok = 1'b1;
            res = '0;
            if (cat == CAT_REG) begin
               va = shadow_regs[fa];
               dst = w[15:11];
               case (rop)
                  OP_ADD: res = va + vb;
                  OP_SUB: res = va - vb;
                  OP_MUL: res = va * vb;
                  OP_AND: res = va & vb;
                  OP_OR:  res = va | vb;
                  OP_XOR: res = va ^ vb;
                  OP_NOR: res = ~(va | vb);
                  default: ok = 1'b0;
               endcase
            end else begin
               dst = fa;
               case (rop)
                  OP_ADDI: res = vb + w[7:0];
                  OP_ANDI: res = vb & w[7:0];
                  OP_ORI:  res = vb | w[7:0];
                  OP_XORI: res = vb ^ w[7:0];
                  default: ok = 1'b0;
               endcase
            end
            if (ok) begin
               shadow_regs[dst] = res;
               r.wrote = 1'b1; r.widx = dst; r.wval = res;
            end else r.status = ST_UNKNOWN;
         end else r.status = ST_UNKNOWN;
         shadow_pc = r.next_pc;
      end
      r.halted = shadow_halt;
      return r;
   endfunction

   // Encoders; unused bits are filled at random
   function automatic logic [31:0] enc_reg(logic [2:0] op, logic [4:0] ra, logic [4:0] rb,
                                           logic [4:0] rd);
      logic [10:0] fill;
      fill = 11'($urandom);
      return {CAT_REG, ra, rb, op, rd, fill};
   endfunction

   function automatic logic [31:0] enc_imm(logic [2:0] op, logic [4:0] rd, logic [4:0] rs,
                                           logic [7:0] imm);
      logic [7:0] fill;
      fill = 8'($urandom);
      return {CAT_IMM, rd, rs, op, fill, imm};
   endfunction

   function automatic logic [31:0] enc_ctl(logic [2:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] off);
      return {CAT_CTRL, op, rs, rt, off};
   endfunction

   // Random word of any kind except BREAK, which would end execution
   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      int k;
      w = $urandom;
      k = $urandom_range(0, 9);
      if (k < 4) w[31:29] = CAT_REG;
      else if (k < 6) w[31:29] = CAT_IMM;
      else if (k < 8) w[31:29] = CAT_CTRL;
      if (w[31:29] == CAT_CTRL && w[28:26] == OP_BREAK) w[28:26] = OP_BEQ;
      return w;
   endfunction

   // Offer one item after a random gap; predict it once accepted
   task automatic send_item(logic cmd, logic [31:0] w, logic [7:0] pidx, logic [31:0] pval);
      int g;
      g = idle_on ? $urandom_range(0, 13) : 0;
      if (g != 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.instruction_word <= w;
      req_ch.preload_index <= pidx;
      req_ch.preload_value <= pval;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.insert(pending_results.size(), core_predict(cmd, w, pidx, pval));
      items_sent++;
   endtask

   task automatic exec_word(logic [31:0] w);
      send_item(CMD_EXECUTE, w, 8'($urandom), $urandom);
   endtask

   task automatic preload(logic [7:0] idx, logic [31:0] val);
      send_item(CMD_PRELOAD, $urandom, idx, val);
   endtask

   // Build a 32-bit constant in rd, using scratch as the multiplier 256
   task automatic load_constant(logic [4:0] rd, logic [4:0] scratch, logic [31:0] val);
      exec_word(enc_imm(OP_ANDI, scratch, scratch, 8'h00));
      exec_word(enc_imm(OP_ADDI, scratch, scratch, 8'h80));
      exec_word(enc_imm(OP_ADDI, scratch, scratch, 8'h80));
      exec_word(enc_imm(OP_ANDI, rd, rd, 8'h00));
      exec_word(enc_imm(OP_ADDI, rd, rd, val[31:24]));
      exec_word(enc_reg(OP_MUL, rd, scratch, rd));
      exec_word(enc_imm(OP_ADDI, rd, rd, val[23:16]));
      exec_word(enc_reg(OP_MUL, rd, scratch, rd));
      exec_word(enc_imm(OP_ADDI, rd, rd, val[15:8]));
      exec_word(enc_reg(OP_MUL, rd, scratch, rd));
      exec_word(enc_imm(OP_ADDI, rd, rd, val[7:0]));
   endtask

   // Drop valid and let the pipeline empty
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // Write the base register, then read it back
   task automatic write_base(logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_DATA_BASE; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      shadow_base = val;
      pwrite <= 1'b0; penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== shadow_base) begin
         $display("%0t base readback: expected %h actual %h", $time, shadow_base, prdata);
         errors++;
      end
      psel <= 1'b0; penable <= 1'b0;
      @(posedge clock);
   endtask

   // Load or store at a chosen word of the data store, possibly misaligned
   task automatic mem_access();
      logic [4:0]  rs, rt, scratch;
      logic [15:0] off;
      logic [31:0] target;
      rs = 5'($urandom); rt = 5'($urandom);
      scratch = 5'(rs + 1 + $urandom_range(0, 29));
      off = 16'($urandom);
      target = shadow_base + 4 * $urandom_range(0, DATA_WORDS - 1) + $urandom_range(0, 3);
      load_constant(rs, scratch, target - off);
      exec_word(enc_ctl($urandom_range(0, 1) ? OP_LW : OP_SW, rs, rt, off));
      if ($urandom_range(0, 1)) exec_word(enc_ctl(OP_LW, rs, rt, off));
   endtask

   task automatic run_random(int n);
      int stop_at, k;
      logic [4:0] r;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 3) == 0) idle_on = $urandom_range(0, 2) != 0;
         k = $urandom_range(0, 99);
         if (k < 12) mem_access();
         else if (k < 20) preload(8'($urandom), $urandom);
         else if (k < 27) begin
            r = 5'($urandom);
            exec_word(enc_ctl($urandom_range(0, 1) ? OP_BEQ : OP_BGTZ, r, r,
                              16'($urandom)));
         end else exec_word(rand_word());
      end
   endtask

   // Fill every data store word so later loads always see written data
   task automatic test_preload_all();
      for (int i = 0; i < DATA_WORDS; i++) begin
         case (i)
            0: preload(8'(i), 32'h8000_0000);
            1: preload(8'(i), 32'h7FFF_FFFF);
            2: preload(8'(i), 32'h0);
            3: preload(8'(i), 32'hFFFF_FFFF);
            default: preload(8'(i), $urandom);
         endcase
      end
   endtask

   // Every operation but BREAK, field extremes and the special cases, at reset base
   task automatic test_directed();
      exec_word(enc_imm(OP_ADDI, 5'd1, 5'd0, 8'hFF));
      exec_word(enc_reg(OP_NOR, 5'd0, 5'd0, 5'd2));
      exec_word(enc_reg(OP_ADD, 5'd1, 5'd2, 5'd3));
      exec_word(enc_reg(OP_SUB, 5'd0, 5'd1, 5'd4));
      exec_word(enc_reg(OP_MUL, 5'd2, 5'd2, 5'd5));
      exec_word(enc_reg(OP_AND, 5'd1, 5'd2, 5'd6));
      exec_word(enc_reg(OP_OR, 5'd1, 5'd4, 5'd7));
      exec_word(enc_reg(OP_XOR, 5'd1, 5'd2, 5'd31));
      exec_word(enc_imm(OP_ANDI, 5'd8, 5'd2, 8'hFF));
      exec_word(enc_imm(OP_ORI, 5'd9, 5'd0, 8'h00));
      exec_word(enc_imm(OP_XORI, 5'd10, 5'd2, 8'hAA));
      // unknown words: spare opcodes and categories
      exec_word(enc_reg(3'd7, 5'd1, 5'd2, 5'd11));
      for (int op = OP_XORI + 1; op < 8; op++)
         exec_word(enc_imm(3'(op), 5'd12, 5'd1, 8'($urandom)));
      for (int c = 0; c < 8; c++)
         if (!(c inside {CAT_CTRL, CAT_REG, CAT_IMM})) exec_word({c[2:0], 29'($urandom)});
      for (int op = 0; op < 8; op++)
         if (!(op inside {OP_J, OP_BEQ, OP_BGTZ, OP_BREAK, OP_SW, OP_LW}))
            exec_word(enc_ctl(3'(op), 5'($urandom), 5'($urandom), 16'($urandom)));
      // jumps below and at the top of the code space
      exec_word(enc_ctl(OP_J, 5'd0, 5'd0, 16'h0000));
      exec_word(enc_ctl(OP_J, 5'h1F, 5'h1F, 16'hFFFF));
      // branches taken and not, both offset extremes, zero and negative tests
      exec_word(enc_ctl(OP_BEQ, 5'd0, 5'd0, 16'h8000));
      exec_word(enc_ctl(OP_BEQ, 5'd1, 5'd2, 16'h0004));
      exec_word(enc_ctl(OP_BGTZ, 5'd1, 5'd0, 16'h7FFF));
      exec_word(enc_ctl(OP_BGTZ, 5'd0, 5'd0, 16'h0010));
      exec_word(enc_ctl(OP_BGTZ, 5'd2, 5'd0, 16'h0010));
      // stores and loads: aligned, misaligned, below and above the store
      exec_word(enc_ctl(OP_SW, 5'd0, 5'd1, 16'd128));
      exec_word(enc_ctl(OP_LW, 5'd0, 5'd13, 16'd131));
      exec_word(enc_ctl(OP_LW, 5'd0, 5'd14, 16'd0));
      exec_word(enc_ctl(OP_SW, 5'd0, 5'd1, 16'(128 + 4 * DATA_WORDS)));
      exec_word(enc_ctl(OP_LW, 5'd0, 5'd15, 16'hFFFF));
   endtask

   // Sweep the base register over its extremes and some random values
   task automatic test_base_sweep();
      logic [31:0] bases [5];
      bases = '{32'h0, 32'hFFFF_FFFC, $urandom, $urandom_range(0, 32'hFFFF), BASE_RESET};
      foreach (bases[i]) begin
         drain();
         write_base(bases[i]);
         run_random(220);
      end
   endtask

   // Hold the result side off for a long stretch while items keep coming
   task automatic test_backpressure();
      idle_on = 1'b0;
      stall_requests++;
      repeat (60) exec_word(rand_word());
      idle_on = 1'b1;
   endtask

   // Halt, then show that execution is frozen while preloads still go through
   task automatic test_halt();
      exec_word(enc_ctl(OP_BREAK, 5'($urandom), 5'($urandom), 16'($urandom)));
      exec_word(enc_imm(OP_ADDI, 5'd1, 5'd1, 8'h01));
      preload(8'($urandom), $urandom);
      exec_word(rand_word());
      exec_word(enc_ctl(OP_BREAK, 5'($urandom), 5'($urandom), 16'($urandom)));
   endtask

   // Result side: random stalls per item, plus the long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (stall_requests != stall_served) begin
         stall_served <= stall_requests;
         hold_left <= 300;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= (hold_left == 1);
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_gap <= idle_on ? $urandom_range(0, 13) : 0;
         rsp_ch.ready <= !idle_on || ($urandom_range(0, 1) == 0);
      end else if (rsp_gap != 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ch.ready <= (rsp_gap == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      core_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: expected none actual pc %h", $time, rsp_ch.next_pc);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.next_pc !== want.next_pc) begin
               $display("%0t next_pc: expected %h actual %h", $time, want.next_pc,
                        rsp_ch.next_pc);
               errors++;
            end
            if (rsp_ch.halted !== want.halted) begin
               $display("%0t halted: expected %b actual %b", $time, want.halted,
                        rsp_ch.halted);
               errors++;
            end
            if (rsp_ch.wrote_register !== want.wrote) begin
               $display("%0t wrote_register: expected %b actual %b", $time, want.wrote,
                        rsp_ch.wrote_register);
               errors++;
            end
            if (rsp_ch.written_index !== want.widx) begin
               $display("%0t written_index: expected %0d actual %0d", $time, want.widx,
                        rsp_ch.written_index);
               errors++;
            end
            if (rsp_ch.written_value !== want.wval) begin
               $display("%0t written_value: expected %h actual %h", $time, want.wval,
                        rsp_ch.written_value);
               errors++;
            end
            if (rsp_ch.status !== want.status) begin
               $display("%0t status: expected %0d actual %0d", $time, want.status,
                        rsp_ch.status);
               errors++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("risc_subset_decode_execute_top regression: fail");
      $finish;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = CMD_EXECUTE;
      req_ch.instruction_word = '0;
      req_ch.preload_index = '0;
      req_ch.preload_value = '0;
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      shadow_pc = '0;
      shadow_halt = 1'b0;
      shadow_base = BASE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_base(BASE_RESET);
      test_preload_all();
      test_directed();
      run_random(200);
      test_backpressure();
      test_base_sweep();
      test_halt();

      drain();
      $display("Sent %0d items, checked %0d results: %0d in-range memory accesses,",
               items_sent, results_seen, mem_hits);
      $display("%0d taken branches, six base address settings, halt at the end.",
               branches_taken);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("risc_subset_decode_execute_top regression: pass");
      end else begin
         $display("risc_subset_decode_execute_top regression: fail");
      end
      $finish;
   end

endmodule
